// ----- rtl/core/rgbxq_pkg.sv -----
`default_nettype none

package rgbxq_pkg;

	// Distance weights and luma coefficients
	localparam int unsigned W_RED   = 30;
	localparam int unsigned W_GREEN = 59;
	localparam int unsigned W_BLUE  = 11;
	localparam int unsigned Y_RED   = 54;
	localparam int unsigned Y_GREEN = 183;
	localparam int unsigned Y_BLUE  = 19;
	localparam int unsigned Y_ROUND = 128;

	// Cube level thresholds
	localparam int unsigned CUBE_T1 = 48;
	localparam int unsigned CUBE_T2 = 115;
	localparam int unsigned CUBE_T3 = 155;
	localparam int unsigned CUBE_T4 = 195;
	localparam int unsigned CUBE_T5 = 235;

	// Gray ramp
	localparam int unsigned GRAY_LO     = 8;
	localparam int unsigned GRAY_HI     = 238;
	localparam int unsigned GRAY_BIAS   = 3;
	localparam int unsigned GRAY_LAST   = 23;
	localparam int unsigned GRAY_BASE   = 232;
	localparam int unsigned CUBE_BASE   = 16;
	// x/10 == (x*205)>>11 for x < 1029
	localparam int unsigned DIV10_MUL   = 205;
	localparam int unsigned DIV10_SHIFT = 11;

	localparam int unsigned PIX_W  = 8;
	localparam int unsigned LVL_W  = 3;
	localparam int unsigned STEP_W = 5;
	localparam int unsigned SQ_W   = 2 * PIX_W;
	localparam int unsigned DIST_W = 23;
	localparam int unsigned LUMA_W = 16;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [LVL_W-1:0]  lvl_t;
	typedef logic [STEP_W-1:0] step_t;
	typedef logic [SQ_W-1:0]   sq_t;
	typedef logic [DIST_W-1:0] dist_t;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
		lvl_t qr;
		lvl_t qg;
		lvl_t qb;
		pix_t luma;
	} s1_t;

	typedef struct packed {
		pix_t dcr;
		pix_t dcg;
		pix_t dcb;
		pix_t dgr;
		pix_t dgg;
		pix_t dgb;
		pix_t cube_idx;
		pix_t gray_idx;
	} s2_t;

	typedef struct packed {
		sq_t  scr;
		sq_t  scg;
		sq_t  scb;
		sq_t  sgr;
		sq_t  sgg;
		sq_t  sgb;
		pix_t cube_idx;
		pix_t gray_idx;
	} s3_t;

	typedef struct packed {
		dist_t cube_d;
		dist_t gray_d;
		pix_t  cube_idx;
		pix_t  gray_idx;
	} s4_t;

	function automatic lvl_t quant_level(input pix_t v);
		lvl_t q;
		priority if (v < PIX_W'(CUBE_T1)) q = LVL_W'(0);
		else if (v < PIX_W'(CUBE_T2)) q = LVL_W'(1);
		else if (v < PIX_W'(CUBE_T3)) q = LVL_W'(2);
		else if (v < PIX_W'(CUBE_T4)) q = LVL_W'(3);
		else if (v < PIX_W'(CUBE_T5)) q = LVL_W'(4);
		else q = LVL_W'(5);
		return q;
	endfunction

	function automatic pix_t level_value(input lvl_t q);
		pix_t v;
		unique case (q)
			LVL_W'(0): v = PIX_W'(0);
			LVL_W'(1): v = PIX_W'(95);
			LVL_W'(2): v = PIX_W'(135);
			LVL_W'(3): v = PIX_W'(175);
			LVL_W'(4): v = PIX_W'(215);
			default:   v = PIX_W'(255);
		endcase
		return v;
	endfunction

	function automatic step_t gray_step(input pix_t l);
		logic [PIX_W-1:0]  x;
		logic [2*PIX_W-1:0] p;
		step_t s;
		x = l - PIX_W'(GRAY_BIAS);
		p = (2*PIX_W)'(x) * (2*PIX_W)'(DIV10_MUL);
		priority if (l <= PIX_W'(GRAY_LO)) s = STEP_W'(0);
		else if (l >= PIX_W'(GRAY_HI)) s = STEP_W'(GRAY_LAST);
		else s = p[DIV10_SHIFT +: STEP_W];
		return s;
	endfunction

	function automatic pix_t abs_diff(input pix_t a, input pix_t b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rgb_to_xterm256_quantizer_core.sv -----
`default_nettype none

// RGB to xterm-256 palette quantizer.
// Input channel: in_valid / in_stall with red, green, blue (8 bits each).
// Output channel: out_valid / out_stall with palette_index (16..231 for a
// cube color, 232..255 for a gray ramp step).
// A request is taken at a clock edge with valid high and stall low.
// Five register stages: quantize + luma, candidate diffs, squares,
// weighted distances, compare/select. One pixel per cycle is sustained
// while the output is not stalled. Each stage has its own valid bit and
// loads when it is empty or the stage after it moves, so bubbles collapse
// while the output is stalled and the input keeps taking requests until
// all five stages hold data. A stalled result holds steady on the output
// until taken.
// Reset (arst_n low, asynchronous) empties all stages; no pixel state is
// kept across requests.
module rgb_to_xterm256_quantizer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      palette_index
);

	// Per-stage valid and ready
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	rgbxq_pkg::s1_t   p_s1;
	rgbxq_pkg::s2_t   p_s2;
	rgbxq_pkg::s3_t   p_s3;
	rgbxq_pkg::s4_t   p_s4;
	rgbxq_pkg::pix_t  palette_index_s5;

	rgbxq_pkg::s1_t   n1;
	rgbxq_pkg::s2_t   n2;
	rgbxq_pkg::s3_t   n3;
	rgbxq_pkg::s4_t   n4;
	rgbxq_pkg::pix_t  n5;

	logic [rgbxq_pkg::LUMA_W-1:0] luma_sum;
	rgbxq_pkg::step_t             step;
	rgbxq_pkg::pix_t              gv;
	rgbxq_pkg::pix_t              lr, lg, lb;

	// A stage can load when it is empty or its content moves on
	assign rdy5 = !v_s5 || !out_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign in_stall      = !rdy1;
	assign out_valid     = v_s5;
	assign palette_index = palette_index_s5;

	// Stage 1: cube levels and rounded luma
	always_comb begin
		luma_sum = rgbxq_pkg::LUMA_W'(rgbxq_pkg::Y_RED) * rgbxq_pkg::LUMA_W'(red)
			+ rgbxq_pkg::LUMA_W'(rgbxq_pkg::Y_GREEN) * rgbxq_pkg::LUMA_W'(green)
			+ rgbxq_pkg::LUMA_W'(rgbxq_pkg::Y_BLUE) * rgbxq_pkg::LUMA_W'(blue)
			+ rgbxq_pkg::LUMA_W'(rgbxq_pkg::Y_ROUND);
		n1.red   = red;
		n1.green = green;
		n1.blue  = blue;
		n1.qr    = rgbxq_pkg::quant_level(red);
		n1.qg    = rgbxq_pkg::quant_level(green);
		n1.qb    = rgbxq_pkg::quant_level(blue);
		n1.luma  = luma_sum[rgbxq_pkg::LUMA_W-1 -: rgbxq_pkg::PIX_W];
	end

	// Stage 2: gray step, candidate indices, channel distances
	always_comb begin
		step = rgbxq_pkg::gray_step(p_s1.luma);
		gv   = rgbxq_pkg::PIX_W'(rgbxq_pkg::GRAY_LO) + rgbxq_pkg::PIX_W'(step) * 8'd10;
		lr   = rgbxq_pkg::level_value(p_s1.qr);
		lg   = rgbxq_pkg::level_value(p_s1.qg);
		lb   = rgbxq_pkg::level_value(p_s1.qb);
		n2.dcr = rgbxq_pkg::abs_diff(p_s1.red, lr);
		n2.dcg = rgbxq_pkg::abs_diff(p_s1.green, lg);
		n2.dcb = rgbxq_pkg::abs_diff(p_s1.blue, lb);
		n2.dgr = rgbxq_pkg::abs_diff(p_s1.red, gv);
		n2.dgg = rgbxq_pkg::abs_diff(p_s1.green, gv);
		n2.dgb = rgbxq_pkg::abs_diff(p_s1.blue, gv);
		n2.cube_idx = rgbxq_pkg::PIX_W'(rgbxq_pkg::CUBE_BASE)
			+ rgbxq_pkg::PIX_W'(p_s1.qr) * 8'd36
			+ rgbxq_pkg::PIX_W'(p_s1.qg) * 8'd6
			+ rgbxq_pkg::PIX_W'(p_s1.qb);
		n2.gray_idx = rgbxq_pkg::PIX_W'(rgbxq_pkg::GRAY_BASE) + rgbxq_pkg::PIX_W'(step);
	end

	// Stage 3: squares
	always_comb begin
		n3.scr = rgbxq_pkg::SQ_W'(p_s2.dcr) * rgbxq_pkg::SQ_W'(p_s2.dcr);
		n3.scg = rgbxq_pkg::SQ_W'(p_s2.dcg) * rgbxq_pkg::SQ_W'(p_s2.dcg);
		n3.scb = rgbxq_pkg::SQ_W'(p_s2.dcb) * rgbxq_pkg::SQ_W'(p_s2.dcb);
		n3.sgr = rgbxq_pkg::SQ_W'(p_s2.dgr) * rgbxq_pkg::SQ_W'(p_s2.dgr);
		n3.sgg = rgbxq_pkg::SQ_W'(p_s2.dgg) * rgbxq_pkg::SQ_W'(p_s2.dgg);
		n3.sgb = rgbxq_pkg::SQ_W'(p_s2.dgb) * rgbxq_pkg::SQ_W'(p_s2.dgb);
		n3.cube_idx = p_s2.cube_idx;
		n3.gray_idx = p_s2.gray_idx;
	end

	// Stage 4: weighted distances (max 100*255^2, fits 23 bits)
	always_comb begin
		n4.cube_d = rgbxq_pkg::DIST_W'(rgbxq_pkg::W_RED) * rgbxq_pkg::DIST_W'(p_s3.scr)
			+ rgbxq_pkg::DIST_W'(rgbxq_pkg::W_GREEN) * rgbxq_pkg::DIST_W'(p_s3.scg)
			+ rgbxq_pkg::DIST_W'(rgbxq_pkg::W_BLUE) * rgbxq_pkg::DIST_W'(p_s3.scb);
		n4.gray_d = rgbxq_pkg::DIST_W'(rgbxq_pkg::W_RED) * rgbxq_pkg::DIST_W'(p_s3.sgr)
			+ rgbxq_pkg::DIST_W'(rgbxq_pkg::W_GREEN) * rgbxq_pkg::DIST_W'(p_s3.sgg)
			+ rgbxq_pkg::DIST_W'(rgbxq_pkg::W_BLUE) * rgbxq_pkg::DIST_W'(p_s3.sgb);
		n4.cube_idx = p_s3.cube_idx;
		n4.gray_idx = p_s3.gray_idx;
	end

	// Stage 5: gray only on a strictly smaller distance; ties go to the cube
	assign n5 = (p_s4.gray_d < p_s4.cube_d) ? p_s4.gray_idx : p_s4.cube_idx;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		if (rdy1) p_s1 <= n1;
		if (rdy2) p_s2 <= n2;
		if (rdy3) p_s3 <= n3;
		if (rdy4) p_s4 <= n4;
		if (rdy5) palette_index_s5 <= n5;
	end

endmodule

`default_nettype wire
